FILE: src/wfst_pkg.sv
// ----------------------------------------------------------------------------
// wfst_pkg: weighted fair scheduler table package
// Field widths, operation and state codes, slot entry type, weight table.
// ----------------------------------------------------------------------------
package wfst_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int MODE_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int TICK_W  = 16;
  localparam int NXT_W   = 2;
  localparam int CH_W    = 16;
  localparam int NICE_W  = 6;
  localparam int STAT_W  = 2;
  localparam int SLICE_W = 16;
  localparam int TW_W    = 23;
  localparam int VR_W    = 31;
  localparam int EP_W    = 8;
  localparam int RT_W    = 32;
  localparam int TS_W    = 3;
  localparam int W_W     = 17;
  localparam int W_MAX   = 88761;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int DVD_W   = SLICE_W + W_W;
  localparam int NICE_MAX = 39;

  localparam logic [VR_W-1:0]    VR_MAX       = {VR_W{1'b1}};
  localparam logic [RT_W-1:0]    RT_MAX       = {RT_W{1'b1}};
  localparam logic [EP_W-1:0]    EP_MAX       = {EP_W{1'b1}};
  localparam logic [VR_W-1:0]    VR_LIMIT_RST = 31'd2147483647;
  localparam logic [SLICE_W-1:0] SLICE_RST    = 16'd10000;
  localparam logic [NICE_W-1:0]  NICE_RST     = 6'd20;
  localparam logic [NICE_W-1:0]  NICE_TOP     = 6'd39;

  typedef enum logic [MODE_W-1:0] {
    M_CREATE = 3'd0, M_PICK = 3'd1, M_CHARGE = 3'd2, M_WAKEUP = 3'd3,
    M_NICE   = 3'd4, M_KILL = 3'd5, M_FREE   = 3'd6, M_READ   = 3'd7
  } mode_t;

  typedef enum logic [TS_W-1:0] {
    TS_UNUSED = 3'd0, TS_EMBRYO = 3'd1, TS_SLEEPING = 3'd2,
    TS_RUNNABLE = 3'd3, TS_RUNNING = 3'd4, TS_ZOMBIE = 3'd5
  } task_st_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK = 2'd0, ST_NONE = 2'd1, ST_BAD = 2'd2, ST_WRONG = 2'd3
  } status_t;

  typedef enum logic [NXT_W-1:0] {
    NX_RUNNABLE = 2'd0, NX_SLEEPING = 2'd1, NX_ZOMBIE = 2'd2, NX_BAD = 2'd3
  } next_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    R_VR_LIMIT = 2'd0, R_SLICE = 2'd1, R_DEF_NICE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_GATHER, S_CALC, S_DIV, S_APPLY, S_DONE
  } fsm_t;

  typedef struct packed {
    task_st_t          state;
    logic [NICE_W-1:0] nice;
    logic [VR_W-1:0]   vr;
    logic [EP_W-1:0]   ep;
    logic [RT_W-1:0]   rt;
    logic [CH_W-1:0]   ch;
    logic              killed;
  } entry_t;

  function automatic logic [W_W-1:0] nice_weight(input logic [NICE_W-1:0] n);
    logic [W_W-1:0] w;
    case (n)
      6'd0:  w = 17'd88761; 6'd1:  w = 17'd71755; 6'd2:  w = 17'd56483;
      6'd3:  w = 17'd46273; 6'd4:  w = 17'd36291; 6'd5:  w = 17'd29154;
      6'd6:  w = 17'd23254; 6'd7:  w = 17'd18705; 6'd8:  w = 17'd14949;
      6'd9:  w = 17'd11916; 6'd10: w = 17'd9548;  6'd11: w = 17'd7620;
      6'd12: w = 17'd6100;  6'd13: w = 17'd4904;  6'd14: w = 17'd3906;
      6'd15: w = 17'd3121;  6'd16: w = 17'd2501;  6'd17: w = 17'd1991;
      6'd18: w = 17'd1586;  6'd19: w = 17'd1277;  6'd20: w = 17'd1024;
      6'd21: w = 17'd820;   6'd22: w = 17'd655;   6'd23: w = 17'd526;
      6'd24: w = 17'd423;   6'd25: w = 17'd335;   6'd26: w = 17'd272;
      6'd27: w = 17'd215;   6'd28: w = 17'd172;   6'd29: w = 17'd137;
      6'd30: w = 17'd110;   6'd31: w = 17'd87;    6'd32: w = 17'd70;
      6'd33: w = 17'd56;    6'd34: w = 17'd45;    6'd35: w = 17'd36;
      6'd36: w = 17'd29;    6'd37: w = 17'd23;    6'd38: w = 17'd18;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

endpackage

FILE: src/wfst_req_if.sv
// ----------------------------------------------------------------------------
// wfst_req_if: request channel
// Valid/ready channel carrying one scheduler operation per beat.
// ----------------------------------------------------------------------------
interface wfst_req_if import wfst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot;
  logic              inherit;
  logic [TICK_W-1:0] run_ticks;
  logic [NXT_W-1:0]  next_state;
  logic [CH_W-1:0]   channel;
  logic [NICE_W-1:0] new_nice;

  modport source (output valid, mode, slot, inherit, run_ticks, next_state, channel,
                  new_nice, input ready);
  modport sink   (input valid, mode, slot, inherit, run_ticks, next_state, channel,
                  new_nice, output ready);
endinterface

FILE: src/wfst_rsp_if.sv
// ----------------------------------------------------------------------------
// wfst_rsp_if: response channel
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface wfst_rsp_if import wfst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  chosen_slot;
  logic [SLICE_W-1:0] timeslice;
  logic [TW_W-1:0]    weight_sum;
  logic [NICE_W-1:0]  nice_level;
  logic [VR_W-1:0]    vruntime_out;
  logic [EP_W-1:0]    epoch_out;
  logic [RT_W-1:0]    runtime_out;
  logic [TS_W-1:0]    slot_state;

  modport source (output valid, status, chosen_slot, timeslice, weight_sum, nice_level,
                  vruntime_out, epoch_out, runtime_out, slot_state, input ready);
  modport sink   (input valid, status, chosen_slot, timeslice, weight_sum, nice_level,
                  vruntime_out, epoch_out, runtime_out, slot_state, output ready);
endinterface

FILE: src/wfst_cell.sv
// ----------------------------------------------------------------------------
// wfst_cell: task slot cell
// Holds one slot entry and passes it to its neighbour when the ring turns.
// ----------------------------------------------------------------------------
module wfst_cell import wfst_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.state <= TS_UNUSED;
    end else if (shift) begin
      q.state <= d.state;
    end
    if (shift) begin
      q.nice   <= d.nice;
      q.vr     <= d.vr;
      q.ep     <= d.ep;
      q.rt     <= d.rt;
      q.ch     <= d.ch;
      q.killed <= d.killed;
    end
  end

endmodule

FILE: src/wfst_div.sv
// ----------------------------------------------------------------------------
// wfst_div: restoring divider
// One quotient bit per cycle; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module wfst_div #(
  parameter int DVD_BITS = 33,
  parameter int DVS_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                done,
  output logic [DVD_BITS-1:0] quotient
);

  localparam int CW = $clog2(DVD_BITS);

  logic                busy;
  logic [CW-1:0]       cnt;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS:0]   trial;
  logic                fits;

  assign trial = {rem, quotient[DVD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DVS_BITS'(trial - {1'b0, dvs}) : DVS_BITS'(trial);
      quotient <= {quotient[DVD_BITS-2:0], fits};
    end
  end

endmodule

FILE: src/weighted_fair_scheduler_table.sv
// ----------------------------------------------------------------------------
// weighted_fair_scheduler_table: weighted fair task scheduler table
// Ring of task slot cells with a sequencer and a shared divider.
// ----------------------------------------------------------------------------
// Usage: one operation enters on req per beat and one result leaves on rsp.
// req is taken only while the sequencer is idle; rsp holds its result in an
// output register until taken, and the next request may be accepted while it
// waits. cfg_we/cfg_index/cfg_data write the registers; the user must write
// them only while idle, as the block itself does not enforce this. Each
// operation turns the slot ring twice: one lap gathers (first unused slot,
// least runnable slot, first sleeping slot on the channel, weight sum,
// addressed entry), one lap applies the change. pick and charge run the
// divider in between, one quotient bit per cycle. A new operation is not
// taken until the sequencer has finished the last one and is idle again.
// Reset marks every slot unused at once and restores the register defaults;
// no clearing pass. A stalled rsp holds the result; a further result waits
// in the sequencer until rsp frees.
// ----------------------------------------------------------------------------
module weighted_fair_scheduler_table import wfst_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  wfst_req_if.sink             req,
  wfst_rsp_if.source           rsp
);

  localparam int CNT_W = $clog2(NUM_SLOTS);
  localparam int SUM_W = $clog2(NUM_SLOTS * W_MAX + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_SLOTS - 1);

  fsm_t fsm, fsm_next;

  logic [VR_W-1:0]    vr_limit;
  logic [SLICE_W-1:0] slice_total;
  logic [NICE_W-1:0]  def_nice;

  mode_t              op_mode;
  logic [SLOT_W-1:0]  op_slot;
  logic               op_inherit;
  logic [TICK_W-1:0]  op_ticks;
  next_t              op_nxt;
  logic [CH_W-1:0]    op_chan;
  logic [NICE_W-1:0]  op_nice;

  logic [CNT_W-1:0]   cnt;
  logic               found_free, has_best, found_wake;
  logic [CNT_W-1:0]   free_idx, best_idx, wake_idx;
  logic [EP_W-1:0]    best_ep;
  logic [VR_W-1:0]    best_vr;
  logic [W_W-1:0]     best_w;
  logic [SUM_W-1:0]   sum;
  entry_t             tgt;

  status_t            res_status;
  logic [SLOT_W-1:0]  res_chosen;
  logic               rep_valid, apply;
  logic [CNT_W-1:0]   rep_idx;
  entry_t             rep;
  logic [DVD_W-1:0]   dvd;
  logic [SUM_W-1:0]   dvs;
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_quo, qres;

  entry_t             cq [NUM_SLOTS];
  entry_t             head, head_new;
  logic               shift;
  logic               req_fire;

  // Calc outputs
  status_t            c_status;
  logic [SLOT_W-1:0]  c_chosen;
  logic               c_rep_valid, c_apply, c_div;
  logic [CNT_W-1:0]   c_rep_idx;
  logic               slot_ok;
  logic [CNT_W-1:0]   slot_idx;

  // Charge arithmetic
  logic [RT_W:0]      rt_sum;
  logic [RT_W-1:0]    total, over_amt;
  logic               head_run, head_less;

  assign head     = cq[0];
  assign shift    = (fsm == S_GATHER) || (fsm == S_APPLY);
  assign req_fire = req.valid && req.ready;
  assign slot_ok  = {{(32-SLOT_W){1'b0}}, op_slot} < 32'(NUM_SLOTS);
  assign slot_idx = CNT_W'(op_slot);

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ring
    entry_t d;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign d = (fsm == S_APPLY) ? head_new : head;
    end else begin : g_mid
      assign d = cq[i+1];
    end
    wfst_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(d), .q(cq[i]));
  end

  wfst_div #(.DVD_BITS(DVD_W), .DVS_BITS(SUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(div_quo)
  );

  assign head_run  = head.state == TS_RUNNABLE;
  assign head_less = (head.ep < best_ep) || ((head.ep == best_ep) && (head.vr < best_vr));

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vr_limit    <= VR_LIMIT_RST;
      slice_total <= SLICE_RST;
      def_nice    <= NICE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_VR_LIMIT: vr_limit    <= cfg_data[VR_W-1:0];
        R_SLICE:    slice_total <= cfg_data[SLICE_W-1:0];
        R_DEF_NICE: def_nice    <= cfg_data[NICE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      S_IDLE:   if (req_fire) fsm_next = S_GATHER;
      S_GATHER: if (cnt == LAST) fsm_next = S_CALC;
      S_CALC:   fsm_next = c_div ? S_DIV : S_APPLY;
      S_DIV:    if (div_done) fsm_next = S_APPLY;
      S_APPLY:  if (cnt == LAST) fsm_next = S_DONE;
      S_DONE:   if (!rsp.valid || rsp.ready) fsm_next = S_IDLE;
      default:  fsm_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (fsm == S_IDLE) && !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      cnt       <= '0;
      div_start <= 1'b0;
    end else begin
      fsm       <= fsm_next;
      div_start <= (fsm == S_CALC) && c_div;
      if (shift) begin
        cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      end
    end
  end

  // Decide outcome from gathered data
  always_comb begin
    c_status    = ST_NONE;
    c_chosen    = '0;
    c_rep_valid = 1'b0;
    c_rep_idx   = slot_idx;
    c_apply     = 1'b0;
    c_div       = 1'b0;
    unique case (op_mode)
      M_CREATE: if (found_free) begin
        c_status = ST_OK; c_chosen = SLOT_W'(free_idx);
        c_rep_valid = 1'b1; c_rep_idx = free_idx; c_apply = 1'b1;
      end
      M_PICK: if (has_best) begin
        c_status = ST_OK; c_chosen = SLOT_W'(best_idx);
        c_rep_valid = 1'b1; c_rep_idx = best_idx; c_apply = 1'b1; c_div = 1'b1;
      end
      M_WAKEUP: if (found_wake) begin
        c_status = ST_OK; c_chosen = SLOT_W'(wake_idx);
        c_rep_valid = 1'b1; c_rep_idx = wake_idx; c_apply = 1'b1;
      end
      default: begin
        c_chosen = op_slot;
        if (slot_ok) begin
          c_rep_valid = 1'b1;
          if (op_mode == M_READ) begin
            c_status = ST_OK;
          end else if ((op_mode == M_NICE) && (op_nice > NICE_TOP)) begin
            c_status = ST_BAD;
          end else if (tgt.state == TS_UNUSED) begin
            c_status = ST_NONE;
          end else begin
            case (op_mode)
              M_CHARGE: begin
                if (tgt.state != TS_RUNNING) c_status = ST_WRONG;
                else if (op_nxt == NX_BAD) c_status = ST_BAD;
                else begin
                  c_status = ST_OK; c_apply = 1'b1; c_div = 1'b1;
                end
              end
              M_FREE: begin
                if (tgt.state != TS_ZOMBIE) c_status = ST_WRONG;
                else begin
                  c_status = ST_OK; c_apply = 1'b1;
                end
              end
              default: begin
                c_status = ST_OK; c_apply = 1'b1;
              end
            endcase
          end
        end
      end
    endcase
  end

  // Charge update of the head entry
  always_comb begin
    rt_sum   = {1'b0, head.rt} + (RT_W+1)'(op_ticks);
    total    = {1'b0, head.vr} + RT_W'(qres);
    over_amt = total - {1'b0, vr_limit};
  end

  // Apply lap: modify the entry at the head
  always_comb begin
    head_new = head;
    if (apply) begin
      case (op_mode)
        M_CREATE: if (cnt == free_idx) begin
          head_new.state  = TS_RUNNABLE;
          head_new.nice   = (def_nice > NICE_TOP) ? NICE_TOP : def_nice;
          head_new.vr     = (op_inherit && slot_ok && tgt.state != TS_UNUSED) ? tgt.vr : '0;
          head_new.ep     = (op_inherit && slot_ok && tgt.state != TS_UNUSED) ? tgt.ep : '0;
          head_new.rt     = '0;
          head_new.ch     = '0;
          head_new.killed = 1'b0;
        end
        M_PICK: if (cnt == best_idx) head_new.state = TS_RUNNING;
        M_WAKEUP: if (head.state == TS_SLEEPING && head.ch == op_chan) begin
          head_new.state = TS_RUNNABLE;
          head_new.ep    = best_ep;
          head_new.vr    = best_vr;
        end
        M_CHARGE: if (cnt == slot_idx) begin
          head_new.rt = rt_sum[RT_W] ? RT_MAX : rt_sum[RT_W-1:0];
          if (total > {1'b0, vr_limit}) begin
            if (head.ep == EP_MAX) begin
              head_new.vr = vr_limit;
            end else begin
              head_new.vr = (over_amt > {1'b0, VR_MAX}) ? VR_MAX : over_amt[VR_W-1:0];
              head_new.ep = head.ep + 1'b1;
            end
          end else begin
            head_new.vr = total[VR_W-1:0];
          end
          case (op_nxt)
            NX_RUNNABLE: head_new.state = TS_RUNNABLE;
            NX_SLEEPING: begin
              head_new.state = TS_SLEEPING;
              head_new.ch    = op_chan;
            end
            default: head_new.state = TS_ZOMBIE;
          endcase
        end
        M_NICE: if (cnt == slot_idx) head_new.nice = op_nice;
        M_KILL: if (cnt == slot_idx) begin
          head_new.killed = 1'b1;
          if (head.state == TS_SLEEPING) head_new.state = TS_RUNNABLE;
        end
        M_FREE: if (cnt == slot_idx) begin
          head_new.state  = TS_UNUSED;
          head_new.killed = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_mode    <= mode_t'(req.mode);
      op_slot    <= req.slot;
      op_inherit <= req.inherit;
      op_ticks   <= req.run_ticks;
      op_nxt     <= next_t'(req.next_state);
      op_chan    <= req.channel;
      op_nice    <= req.new_nice;
      found_free <= 1'b0;
      has_best   <= 1'b0;
      found_wake <= 1'b0;
      free_idx   <= '0;
      best_idx   <= '0;
      wake_idx   <= '0;
      best_ep    <= '0;
      best_vr    <= '0;
      best_w     <= '0;
      sum        <= '0;
    end
    if (fsm == S_GATHER) begin
      if (head.state == TS_UNUSED && !found_free) begin
        found_free <= 1'b1;
        free_idx   <= cnt;
      end
      if (head_run) begin
        sum <= sum + SUM_W'(nice_weight(head.nice));
        if (!has_best || head_less) begin
          has_best <= 1'b1;
          best_idx <= cnt;
          best_ep  <= head.ep;
          best_vr  <= head.vr;
          best_w   <= nice_weight(head.nice);
        end
      end
      if (head.state == TS_SLEEPING && head.ch == op_chan && !found_wake) begin
        found_wake <= 1'b1;
        wake_idx   <= cnt;
      end
      if (cnt == slot_idx) tgt <= head;
    end
    if (fsm == S_CALC) begin
      res_status <= c_status;
      res_chosen <= c_chosen;
      rep_valid  <= c_rep_valid;
      rep_idx    <= c_rep_idx;
      apply      <= c_apply;
      qres       <= '0;
      if (op_mode == M_PICK) begin
        dvd <= slice_total * best_w;
        dvs <= sum;
      end else begin
        dvd <= DVD_W'({op_ticks, 10'd0});
        dvs <= SUM_W'(nice_weight(tgt.nice));
      end
    end
    if (div_done) qres <= div_quo;
    if (fsm == S_APPLY && cnt == rep_idx) rep <= head_new;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fsm == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fsm == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status       <= res_status;
      rsp.chosen_slot  <= res_chosen;
      rsp.timeslice    <= (op_mode == M_PICK && res_status == ST_OK) ? SLICE_W'(qres) : '0;
      rsp.weight_sum   <= (op_mode == M_PICK && res_status == ST_OK) ? TW_W'(sum) : '0;
      if (rep_valid && rep.state != TS_UNUSED) begin
        rsp.nice_level   <= rep.nice;
        rsp.vruntime_out <= rep.vr;
        rsp.epoch_out    <= rep.ep;
        rsp.runtime_out  <= rep.rt;
        rsp.slot_state   <= rep.state;
      end else begin
        rsp.nice_level   <= '0;
        rsp.vruntime_out <= '0;
        rsp.epoch_out    <= '0;
        rsp.runtime_out  <= '0;
        rsp.slot_state   <= TS_UNUSED;
      end
    end
  end

  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    fsm == S_IDLE |-> cnt == '0) else $error("ring not aligned when idle");

  a_accept_gathers: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> fsm == S_GATHER) else $error("accepted beat did not start a lap");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> fsm == S_DIV) else $error("divider started outside divide state");

  a_pick_has_weight: assert property (@(posedge clk) disable iff (rst)
    (fsm == S_CALC && op_mode == M_PICK && has_best) |-> sum != '0)
    else $error("pick found a runnable slot but no weight");

endmodule

FILE: tb/sv/weighted_fair_scheduler_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_fair_scheduler_table_tb: self-checking scheduler table bench
// Drives scheduler operations through the request channel and keeps its own
// copy of the slot table to predict every result. The run has several
// register settings, randomised gaps on both channels and one long response
// stall. Each result beat is checked field by field against the prediction.
// ----------------------------------------------------------------------------
module weighted_fair_scheduler_table_tb;
  import wfst_pkg::*;

  localparam int SLOTS = 64;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    mode_t             mode;
    logic [SLOT_W-1:0] slot;
    logic              inherit;
    logic [TICK_W-1:0] ticks;
    logic [NXT_W-1:0]  nxt;
    logic [CH_W-1:0]   chan;
    logic [NICE_W-1:0] nn;
  } op_t;

  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  chosen;
    logic [SLICE_W-1:0] ts;
    logic [TW_W-1:0]    tw;
    logic [NICE_W-1:0]  nice;
    logic [VR_W-1:0]    vr;
    logic [EP_W-1:0]    ep;
    logic [RT_W-1:0]    rt;
    task_st_t           st;
  } outcome_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  wfst_req_if req_ch ();
  wfst_rsp_if rsp_ch ();

  weighted_fair_scheduler_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  int weight_lut [40] = '{
    88761, 71755, 56483, 46273, 36291, 29154, 23254, 18705, 14949, 11916,
    9548, 7620, 6100, 4904, 3906, 3121, 2501, 1991, 1586, 1277,
    1024, 820, 655, 526, 423, 335, 272, 215, 172, 137,
    110, 87, 70, 56, 45, 36, 29, 23, 18, 15
  };

  task_st_t          tbl_st   [SLOTS];
  logic [NICE_W-1:0] tbl_nice [SLOTS];
  logic [VR_W-1:0]   tbl_vr   [SLOTS];
  logic [EP_W-1:0]   tbl_ep   [SLOTS];
  logic [RT_W-1:0]   tbl_rt   [SLOTS];
  logic [CH_W-1:0]   tbl_ch   [SLOTS];
  bit                tbl_kill [SLOTS];
  logic [VR_W-1:0]    lim_reg;
  logic [SLICE_W-1:0] slice_reg;
  logic [NICE_W-1:0]  dnice_reg;

  op_t      pending_ops [$];
  outcome_t outcomes_due [$];
  int       errors;
  int       accepted;
  longint   cycles;
  bit       calm;
  bit       hold;
  int       req_gap;
  int       rsp_stall;

  function automatic int slot_weight(int i);
    return weight_lut[(tbl_nice[i] > NICE_MAX) ? NICE_MAX : tbl_nice[i]];
  endfunction

  function automatic int least_runnable();
    int best;
    best = SLOTS;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_st[i] == TS_RUNNABLE &&
          (best == SLOTS || tbl_ep[i] < tbl_ep[best] ||
           (tbl_ep[i] == tbl_ep[best] && tbl_vr[i] < tbl_vr[best])))
        best = i;
    return best;
  endfunction

  function automatic void fill_slot(inout outcome_t o, input int idx);
    if (idx < SLOTS && tbl_st[idx] != TS_UNUSED) begin
      o.nice = tbl_nice[idx];
      o.vr   = tbl_vr[idx];
      o.ep   = tbl_ep[idx];
      o.rt   = tbl_rt[idx];
      o.st   = tbl_st[idx];
    end
  endfunction

  function automatic outcome_t sched_apply(op_t op);
    outcome_t o;
    int s, f, best, first;
    longint unsigned sum, delta, total, run;
    logic [EP_W-1:0] ep0;
    logic [VR_W-1:0] vr0;
    o = '{ST_OK, '0, '0, '0, '0, '0, '0, '0, TS_UNUSED};
    s = op.slot;
    case (op.mode)
      M_CREATE: begin
        f = SLOTS;
        for (int i = 0; i < SLOTS; i++)
          if (f == SLOTS && tbl_st[i] == TS_UNUSED) f = i;
        if (f == SLOTS) begin
          o.status = ST_NONE;
        end else begin
          tbl_nice[f] = (dnice_reg > NICE_MAX) ? NICE_TOP : dnice_reg;
          tbl_vr[f] = '0;
          tbl_ep[f] = '0;
          if (op.inherit && tbl_st[s] != TS_UNUSED) begin
            tbl_vr[f] = tbl_vr[s];
            tbl_ep[f] = tbl_ep[s];
          end
          tbl_rt[f] = '0;
          tbl_ch[f] = '0;
          tbl_kill[f] = 1'b0;
          tbl_st[f] = TS_RUNNABLE;
          o.chosen = SLOT_W'(f);
          fill_slot(o, f);
        end
      end
      M_PICK: begin
        best = least_runnable();
        sum = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_st[i] == TS_RUNNABLE) sum += slot_weight(i);
        if (best == SLOTS) begin
          o.status = ST_NONE;
        end else begin
          o.ts = SLICE_W'((longint'(slice_reg) * slot_weight(best)) / sum);
          o.tw = TW_W'(sum);
          tbl_st[best] = TS_RUNNING;
          o.chosen = SLOT_W'(best);
          fill_slot(o, best);
        end
      end
      M_WAKEUP: begin
        best = least_runnable();
        ep0 = '0;
        vr0 = '0;
        first = SLOTS;
        if (best != SLOTS) begin
          ep0 = tbl_ep[best];
          vr0 = tbl_vr[best];
        end
        for (int i = 0; i < SLOTS; i++)
          if (tbl_st[i] == TS_SLEEPING && tbl_ch[i] == op.chan) begin
            tbl_st[i] = TS_RUNNABLE;
            tbl_ep[i] = ep0;
            tbl_vr[i] = vr0;
            if (first == SLOTS) first = i;
          end
        if (first == SLOTS) begin
          o.status = ST_NONE;
        end else begin
          o.chosen = SLOT_W'(first);
          fill_slot(o, first);
        end
      end
      default: begin
        o.chosen = SLOT_W'(s);
        if (op.mode == M_READ) begin
          fill_slot(o, s);
        end else if (op.mode == M_NICE && op.nn > NICE_MAX) begin
          o.status = ST_BAD;
          fill_slot(o, s);
        end else if (tbl_st[s] == TS_UNUSED) begin
          o.status = ST_NONE;
        end else if (op.mode == M_CHARGE) begin
          if (tbl_st[s] != TS_RUNNING) begin
            o.status = ST_WRONG;
          end else if (op.nxt == NX_BAD) begin
            o.status = ST_BAD;
          end else begin
            run = longint'(tbl_rt[s]) + op.ticks;
            tbl_rt[s] = (run > RT_MAX) ? RT_MAX : RT_W'(run);
            delta = (longint'(op.ticks) * 1024) / slot_weight(s);
            total = longint'(tbl_vr[s]) + delta;
            if (total > lim_reg) begin
              if (tbl_ep[s] == EP_MAX) begin
                tbl_vr[s] = lim_reg;
              end else begin
                total -= lim_reg;
                tbl_vr[s] = (total > VR_MAX) ? VR_MAX : VR_W'(total);
                tbl_ep[s]++;
              end
            end else begin
              tbl_vr[s] = VR_W'(total);
            end
            if (op.nxt == NX_RUNNABLE) begin
              tbl_st[s] = TS_RUNNABLE;
            end else if (op.nxt == NX_SLEEPING) begin
              tbl_ch[s] = op.chan;
              tbl_st[s] = TS_SLEEPING;
            end else begin
              tbl_st[s] = TS_ZOMBIE;
            end
          end
          fill_slot(o, s);
        end else if (op.mode == M_NICE) begin
          tbl_nice[s] = op.nn;
          fill_slot(o, s);
        end else if (op.mode == M_KILL) begin
          tbl_kill[s] = 1'b1;
          if (tbl_st[s] == TS_SLEEPING) tbl_st[s] = TS_RUNNABLE;
          fill_slot(o, s);
        end else begin
          if (tbl_st[s] != TS_ZOMBIE) begin
            o.status = ST_WRONG;
            fill_slot(o, s);
          end else begin
            tbl_st[s] = TS_UNUSED;
            tbl_kill[s] = 1'b0;
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic int slot_in(task_st_t st);
    int hits [$];
    for (int i = 0; i < SLOTS; i++)
      if (tbl_st[i] == st) hits.push_back(i);
    if (hits.size() == 0) return $urandom_range(0, SLOTS - 1);
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_st[i] != TS_UNUSED) n++;
    return n;
  endfunction

  task automatic issue(mode_t m, int s, bit inh = 0, int tk = 0, int nx = 0,
                       int ch = 0, int nn = 0);
    op_t op;
    op = '{m, SLOT_W'(s), inh, TICK_W'(tk), NXT_W'(nx), CH_W'(ch), NICE_W'(nn)};
    pending_ops.push_back(op);
    outcomes_due.push_back(sched_apply(op));
  endtask

  task automatic issue_random();
    int r, tk, ch;
    r = $urandom_range(0, 99);
    tk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
    if ($urandom_range(0, 9) == 0) tk = 65535;
    ch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
    if (r < 16 && used_count() < 56)
      issue(M_CREATE, $urandom_range(0, SLOTS - 1), $urandom_range(0, 1));
    else if (r < 38)
      issue(M_PICK, $urandom_range(0, SLOTS - 1));
    else if (r < 62)
      issue(M_CHARGE, ($urandom_range(0, 9) < 8) ? slot_in(TS_RUNNING)
                                                 : $urandom_range(0, SLOTS - 1),
            0, tk, ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2), ch);
    else if (r < 70)
      issue(M_WAKEUP, $urandom_range(0, SLOTS - 1), 0, 0, 0,
            ($urandom_range(0, 3) == 0) ? ch : tbl_ch[slot_in(TS_SLEEPING)]);
    else if (r < 77)
      issue(M_NICE, slot_in(TS_RUNNABLE), 0, 0, 0, 0,
            ($urandom_range(0, 5) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 39));
    else if (r < 83)
      issue(M_KILL, ($urandom_range(0, 1) == 0) ? slot_in(TS_SLEEPING)
                                                : $urandom_range(0, SLOTS - 1));
    else if (r < 93)
      issue(M_FREE, ($urandom_range(0, 3) != 0) ? slot_in(TS_ZOMBIE)
                                                : $urandom_range(0, SLOTS - 1));
    else
      issue(mode_t'(M_READ), $urandom_range(0, SLOTS - 1), $urandom_range(0, 1),
            $urandom_range(0, 65535), $urandom_range(0, 3), $urandom_range(0, 65535),
            $urandom_range(0, 63));
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      R_VR_LIMIT: lim_reg   = val;
      R_SLICE:    slice_reg = val[SLICE_W-1:0];
      default:    dnice_reg = val[NICE_W-1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || req_ch.valid || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at beat %0d: %s got %0d expected %0d", accepted, field, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = R_VR_LIMIT;
    cfg_data = '0;
    req_ch.valid = 0;
    req_ch.mode = M_READ;
    req_ch.slot = '0;
    req_ch.inherit = 0;
    req_ch.run_ticks = '0;
    req_ch.next_state = '0;
    req_ch.channel = '0;
    req_ch.new_nice = '0;
    rsp_ch.ready = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** weighted_fair_scheduler_table: FAILED **");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    op_t op;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap <= 0;
    end else if (!(req_ch.valid && !req_ch.ready)) begin
      if (req_ch.valid) accepted++;
      if (req_gap > 0) begin
        req_ch.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= op.mode;
        req_ch.slot       <= op.slot;
        req_ch.inherit    <= op.inherit;
        req_ch.run_ticks  <= op.ticks;
        req_ch.next_state <= op.nxt;
        req_ch.channel    <= op.chan;
        req_ch.new_nice   <= op.nn;
        req_gap <= calm ? 0 : $urandom_range(0, 7);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t want;
    int stall_n;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      stall_n = (rsp_stall > 0) ? rsp_stall - 1 : 0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        stall_n = calm ? 0 : $urandom_range(0, 7);
        if (outcomes_due.size() == 0) begin
          report("unexpected beat, status", rsp_ch.status, 0);
        end else begin
          want = outcomes_due.pop_front();
          if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
          if (rsp_ch.chosen_slot !== want.chosen)
            report("chosen_slot", rsp_ch.chosen_slot, want.chosen);
          if (rsp_ch.timeslice !== want.ts) report("timeslice", rsp_ch.timeslice, want.ts);
          if (rsp_ch.weight_sum !== want.tw)
            report("weight_sum", rsp_ch.weight_sum, want.tw);
          if (rsp_ch.nice_level !== want.nice)
            report("nice_level", rsp_ch.nice_level, want.nice);
          if (rsp_ch.vruntime_out !== want.vr)
            report("vruntime_out", rsp_ch.vruntime_out, want.vr);
          if (rsp_ch.epoch_out !== want.ep) report("epoch_out", rsp_ch.epoch_out, want.ep);
          if (rsp_ch.runtime_out !== want.rt)
            report("runtime_out", rsp_ch.runtime_out, want.rt);
          if (rsp_ch.slot_state !== want.st)
            report("slot_state", rsp_ch.slot_state, want.st);
        end
      end
      rsp_stall <= stall_n;
      rsp_ch.ready <= !hold && stall_n == 0;
    end
  end

  // long response hold-off while requests keep coming
  initial begin
    hold = 0;
    wait (accepted >= 400);
    @(posedge clk);
    hold <= 1;
    repeat (900) @(posedge clk);
    hold <= 0;
  end

  initial begin
    int s;
    errors = 0;
    accepted = 0;
    cycles = 0;
    calm = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_st[i] = TS_UNUSED;
      tbl_nice[i] = '0;
      tbl_vr[i] = '0;
      tbl_ep[i] = '0;
      tbl_rt[i] = '0;
      tbl_ch[i] = '0;
      tbl_kill[i] = 1'b0;
    end
    lim_reg = VR_LIMIT_RST;
    slice_reg = SLICE_RST;
    dnice_reg = NICE_RST;
    wait (!rst);
    @(posedge clk);

    issue(M_READ, 0);
    issue(M_PICK, 0);
    issue(M_WAKEUP, 0, 0, 0, 0, 7);
    issue(M_CREATE, 9, 1);
    issue(M_CREATE, 0, 0);
    issue(M_NICE, 1, 0, 0, 0, 0, 40);
    issue(M_NICE, 1, 0, 0, 0, 0, 39);
    issue(M_NICE, 0, 0, 0, 0, 0, 0);
    issue(M_CHARGE, 0, 0, 100);
    issue(M_PICK, 0);
    issue(M_CHARGE, 0, 0, 5, NX_BAD);
    issue(M_CHARGE, 0, 0, 65535, NX_SLEEPING, 16'hffff);
    issue(M_NICE, 2, 0, 0, 0, 0, 5);
    issue(M_KILL, 3);
    issue(M_WAKEUP, 0, 0, 0, 0, 16'hffff);
    issue(M_PICK, 0);
    issue(M_CHARGE, slot_in(TS_RUNNING), 0, 65535, NX_ZOMBIE);
    issue(M_FREE, 1);
    issue(M_FREE, slot_in(TS_ZOMBIE));
    issue(M_FREE, 63);
    issue(M_CREATE, 0, 1);
    issue(M_PICK, 0);
    s = slot_in(TS_RUNNING);
    issue(M_CHARGE, s, 0, 0, NX_SLEEPING, 9);
    issue(M_KILL, s);
    issue(M_READ, 63);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(R_VR_LIMIT, 1);
          write_reg(R_SLICE, 1);
          write_reg(R_DEF_NICE, 0);
        end
        2: begin
          write_reg(R_VR_LIMIT, VR_MAX);
          write_reg(R_SLICE, 65535);
          write_reg(R_DEF_NICE, 39);
        end
        3: begin
          write_reg(R_VR_LIMIT, 0);
          write_reg(R_SLICE, 0);
          write_reg(R_DEF_NICE, 63);
        end
        4: begin
          write_reg(R_VR_LIMIT, $urandom_range(1, 100000));
          write_reg(R_SLICE, $urandom_range(1, 65535));
          write_reg(R_DEF_NICE, $urandom_range(40, 62));
        end
        5: begin
          write_reg(R_VR_LIMIT, $urandom_range(1, 32'h7fffffff));
          write_reg(R_SLICE, $urandom_range(1, 65535));
          write_reg(R_DEF_NICE, $urandom_range(0, 39));
        end
        default: ;
      endcase
      calm = (ph == 2);
      if (ph == 3)
        while (used_count() < SLOTS) issue(M_CREATE, $urandom_range(0, SLOTS - 1), 1);
      if (ph == 3) issue(M_CREATE, 0, 0);
      for (int n = 0; n < 210; n++) issue_random();
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** weighted_fair_scheduler_table: PASSED **");
    end else begin
      $display("** weighted_fair_scheduler_table: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/wfst_pkg.sv
src/wfst_req_if.sv
src/wfst_rsp_if.sv
src/wfst_cell.sv
src/wfst_div.sv
src/weighted_fair_scheduler_table.sv
tb/sv/weighted_fair_scheduler_table_tb.sv
